// ----- sv/lerb_pkg.sv -----
// Shared types, codes and sizes for the line-edit receive buffer.
package lerb_pkg;

  localparam int LINE_DEPTH = 64;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] WITHDRAW_RESET = 8'd27;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_POLL = 1'b1;

  localparam logic [1:0] ST_NO_CHANGE   = 2'd0;
  localparam logic [1:0] ST_NEW_CONTENT = 2'd1;
  localparam logic [1:0] ST_LINE_READY  = 2'd2;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } lerb_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] line_length;
    logic [7:0] out_char;
    logic       last;
  } lerb_out_t;

  // controller to datapath
  typedef struct packed {
    logic take_byte;
    logic take_poll;
    logic emit_nochg;
    logic emit_char;
  } lerb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic changed;
    logic at_end;
    logic out_free;
  } lerb_stat_t;

endpackage

// ----- sv/line_edit_receive_buffer.sv -----
// Line-edit receive buffer top level: controller plus datapath.
//
// Collects terminal bytes into a line of at most LINE_DEPTH-1 characters with
// backspace, CR/LF completion and a configurable withdraw character (cfg_we /
// cfg_wdata, reset value 27). A received byte gives no word and leaves in_ready
// high; bytes are ignored while a completed line waits. A poll gives either a
// single no-change word, or one word per stored character followed by a zero
// terminator with last set. A poll occupies the block until its last word is
// loaded, and the single read port of the line store is prefetched one
// character ahead of the output register; stalls on out_ready hold the stream.
// in_ready drops while a poll is being streamed, and the next item can be
// taken while the final word still waits in the output register.
module line_edit_receive_buffer import lerb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  lerb_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output lerb_out_t  out_data
);

  lerb_cmd_t  cmd;
  lerb_stat_t stat;

  // sequence byte handling, poll start and word emission
  lerb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_ready    (in_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  // hold the line, flags, withdraw register and the output word
  lerb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rx_byte   (in_data.rx_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- sv/lerb_ctrl.sv -----
// Controller state machine for the line-edit receive buffer.
module lerb_ctrl import lerb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_req_type,
  output logic       in_ready,
  input  lerb_stat_t stat,
  output lerb_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_NOCHG  = 2'd1;
  localparam logic [1:0] S_STREAM = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_POLL) begin
            cmd.take_poll = 1'b1;
            state_nxt     = stat.changed ? S_STREAM : S_NOCHG;
          end else begin
            cmd.take_byte = 1'b1;
          end
        end
      end
      S_NOCHG: begin
        if (stat.out_free) begin
          cmd.emit_nochg = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_STREAM: begin
        if (stat.out_free) begin
          cmd.emit_char = 1'b1;
          if (stat.at_end) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/lerb_dp.sv -----
// Datapath for the line-edit receive buffer: line store, flags and output register.
module lerb_dp import lerb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic [7:0] rx_byte,
  input  lerb_cmd_t  cmd,
  output lerb_stat_t stat,
  output logic       out_valid,
  input  logic       out_ready,
  output lerb_out_t  out_data
);

  localparam logic [ADDR_W-1:0] FILL_MAX = ADDR_W'(LINE_DEPTH - 1);

  logic [7:0]        mem [LINE_DEPTH];
  logic [7:0]        rd_data_r;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  logic [7:0]        withdraw_r;
  logic [ADDR_W-1:0] fill_r, fill_nxt;
  logic              ready_r, ready_nxt;
  logic              changed_r, changed_nxt;
  logic [1:0]        status_r;
  logic [ADDR_W-1:0] len_r;
  logic [ADDR_W-1:0] idx_r;
  logic              out_valid_r, out_valid_nxt;
  lerb_out_t         out_data_r;

  assign stat.changed  = changed_r;
  assign stat.at_end   = (idx_r == len_r);
  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  // line editing on a received byte, clearing on a reporting poll
  always_comb begin
    fill_nxt    = fill_r;
    ready_nxt   = ready_r;
    changed_nxt = changed_r;
    wr_en       = 1'b0;
    wr_addr     = fill_r;
    wr_data     = rx_byte;
    if (cmd.take_byte && !ready_r) begin
      if (rx_byte == withdraw_r) begin
        wr_en       = 1'b1;
        wr_addr     = '0;
        fill_nxt    = ADDR_W'(1);
        ready_nxt   = 1'b1;
        changed_nxt = 1'b1;
      end else if (rx_byte == CH_CR || rx_byte == CH_LF) begin
        if (fill_r != '0) begin
          ready_nxt   = 1'b1;
          changed_nxt = 1'b1;
        end
      end else if (rx_byte == CH_BS) begin
        if (fill_r != '0) begin
          fill_nxt    = fill_r - ADDR_W'(1);
          changed_nxt = 1'b1;
        end
      end else if (fill_r != FILL_MAX) begin
        wr_en       = 1'b1;
        fill_nxt    = fill_r + ADDR_W'(1);
        changed_nxt = 1'b1;
      end
    end else if (cmd.take_poll && changed_r) begin
      ready_nxt   = 1'b0;
      changed_nxt = 1'b0;
      if (ready_r) begin
        fill_nxt = '0;
      end
    end
  end

  // prefetch the next character while the current one is loaded out
  assign rd_en   = cmd.take_poll || cmd.emit_char;
  assign rd_addr = cmd.take_poll ? '0 : idx_r + ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_nochg || cmd.emit_char) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      withdraw_r  <= WITHDRAW_RESET;
      fill_r      <= '0;
      ready_r     <= 1'b0;
      changed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        withdraw_r <= cfg_wdata;
      end
      fill_r      <= fill_nxt;
      ready_r     <= ready_nxt;
      changed_r   <= changed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_poll) begin
      status_r <= ready_r ? ST_LINE_READY : ST_NEW_CONTENT;
      len_r    <= fill_r;
      idx_r    <= '0;
    end else if (cmd.emit_char) begin
      idx_r <= idx_r + ADDR_W'(1);
    end
    if (cmd.emit_nochg) begin
      out_data_r.status      <= ST_NO_CHANGE;
      out_data_r.line_length <= '0;
      out_data_r.out_char    <= '0;
      out_data_r.last        <= 1'b1;
    end else if (cmd.emit_char) begin
      out_data_r.status      <= status_r;
      out_data_r.line_length <= 6'(len_r);
      out_data_r.out_char    <= stat.at_end ? 8'h00 : rd_data_r;
      out_data_r.last        <= stat.at_end;
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the line-edit receive buffer.
module tb;
  import lerb_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int JAM_CYCLES    = 300;
  localparam int PHASE_ITEMS   = 27;
  localparam int MAX_REPORTS   = 10;
  localparam int NUM_DIRECTED  = 24;
  localparam int NUM_SETTINGS  = 7;

  localparam lerb_out_t NO_CHANGE_WORD  = '{ST_NO_CHANGE, 6'd0, 8'h00, 1'b1};
  localparam lerb_out_t EMPTY_EDIT_WORD = '{ST_NEW_CONTENT, 6'd0, 8'h00, 1'b1};

  // One directed row: the word to send, and for single-word polls whose
  // answer is obvious, the word itself typed in.
  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
    logic       pinned;
    lerb_out_t  word;
  } stim_row_t;

  localparam stim_row_t [0:NUM_DIRECTED-1] DIRECTED_ROWS = '{
    '{REQ_POLL, 8'hA5, 1'b1, NO_CHANGE_WORD},   // nothing since reset
    '{REQ_BYTE, CH_CR, 1'b0, '0},               // end of an empty line
    '{REQ_BYTE, CH_LF, 1'b0, '0},
    '{REQ_BYTE, CH_BS, 1'b0, '0},               // backspace on an empty line
    '{REQ_POLL, 8'h5A, 1'b1, NO_CHANGE_WORD},   // none of those counts as a change
    '{REQ_BYTE, 8'h61, 1'b0, '0},
    '{REQ_BYTE, CH_BS, 1'b0, '0},
    '{REQ_POLL, 8'hFF, 1'b1, EMPTY_EDIT_WORD},  // changed, but empty again
    '{REQ_POLL, 8'h00, 1'b1, NO_CHANGE_WORD},
    '{REQ_BYTE, 8'h00, 1'b0, '0},               // byte extremes are plain chars
    '{REQ_BYTE, 8'hFF, 1'b0, '0},
    '{REQ_BYTE, 8'h41, 1'b0, '0},
    '{REQ_POLL, 8'h3C, 1'b0, '0},               // stream the partial line
    '{REQ_BYTE, CH_CR, 1'b0, '0},               // complete it
    '{REQ_BYTE, 8'h42, 1'b0, '0},               // dropped: line waits
    '{REQ_BYTE, CH_BS, 1'b0, '0},               // dropped as well
    '{REQ_POLL, 8'hC3, 1'b0, '0},               // ready line, then cleared
    '{REQ_POLL, 8'h0F, 1'b1, NO_CHANGE_WORD},
    '{REQ_BYTE, WITHDRAW_RESET, 1'b0, '0},      // withdraw on an empty line
    '{REQ_POLL, 8'hF0, 1'b0, '0},
    '{REQ_BYTE, 8'h55, 1'b0, '0},
    '{REQ_BYTE, CH_LF, 1'b0, '0},
    '{REQ_BYTE, WITHDRAW_RESET, 1'b0, '0},      // withdraw ignored while line waits
    '{REQ_POLL, 8'h99, 1'b0, '0}
  };

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  logic [7:0] cfg_wdata;
  logic      in_valid;
  logic      in_ready;
  lerb_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  lerb_out_t out_data;

  // Typed-in expectation that travels with the word on the input channel.
  logic      row_pinned;
  lerb_out_t row_word;

  // Shadow copy of the buffer state, advanced on every accepted word.
  logic [7:0] shadow_line [LINE_DEPTH];
  int         shadow_fill;
  logic       shadow_ready;
  logic       shadow_changed;
  logic [7:0] shadow_withdraw;

  lerb_out_t pending_words [$];

  int  cycle_count;
  int  mismatches;
  int  items_sent;
  int  words_checked;
  int  polls_seen;
  int  lines_completed;
  int  bytes_dropped;
  int  settings_seen;
  bit  tx_steady;
  bit  rx_steady;
  int  jam_cycles;

  line_edit_receive_buffer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply one accepted word to the shadow state and queue the words it
  // should produce; return how many were queued.
  function automatic int predict_line_words(lerb_in_t item);
    logic [1:0] st;
    int         n;
    n = 0;
    if (item.req_type == REQ_BYTE) begin
      if (!shadow_ready) begin
        // withdraw wins over CR, LF and backspace
        if (item.rx_byte == shadow_withdraw) begin
          shadow_line[0] = item.rx_byte;
          shadow_fill    = 1;
          shadow_ready   = 1'b1;
          shadow_changed = 1'b1;
          lines_completed++;
        end else if (item.rx_byte == CH_CR || item.rx_byte == CH_LF) begin
          if (shadow_fill > 0) begin
            shadow_ready   = 1'b1;
            shadow_changed = 1'b1;
            lines_completed++;
          end
        end else if (item.rx_byte == CH_BS) begin
          if (shadow_fill > 0) begin
            shadow_fill--;
            shadow_changed = 1'b1;
          end
        end else if (shadow_fill + 1 < LINE_DEPTH) begin
          shadow_line[shadow_fill] = item.rx_byte;
          shadow_fill++;
          shadow_changed = 1'b1;
        end else begin
          bytes_dropped++;
        end
      end
    end else begin
      polls_seen++;
      if (!shadow_changed) begin
        pending_words.push_back(NO_CHANGE_WORD);
        n = 1;
      end else begin
        st = shadow_ready ? ST_LINE_READY : ST_NEW_CONTENT;
        for (int i = 0; i < shadow_fill; i++)
          pending_words.push_back('{st, 6'(shadow_fill), shadow_line[i], 1'b0});
        pending_words.push_back('{st, 6'(shadow_fill), 8'h00, 1'b1});
        n = shadow_fill + 1;
        if (st == ST_LINE_READY)
          shadow_fill = 0;
        shadow_ready   = 1'b0;
        shadow_changed = 1'b0;
      end
    end
    return n;
  endfunction

  task automatic check_word(lerb_out_t got);
    lerb_out_t want;
    if (pending_words.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected word: status=%0d len=%0d char=%02h last=%0b",
                 got.status, got.line_length, got.out_char, got.last);
      return;
    end
    want = pending_words.pop_front();
    words_checked++;
    if (got.status !== want.status || got.line_length !== want.line_length ||
        got.out_char !== want.out_char || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $write("mismatch on word %0d: expected status=%0d len=%0d char=%02h last=%0b,",
               words_checked, want.status, want.line_length, want.out_char, want.last);
        $display(" got status=%0d len=%0d char=%02h last=%0b",
                 got.status, got.line_length, got.out_char, got.last);
      end
    end
  endtask

  // Sample both channels at the rising edge; the block's outputs still hold
  // their pre-edge values here. Check first: a word accepted on the input
  // cannot show up on the output in the same cycle.
  always @(posedge clk) begin
    int n;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, pending_words.size());
      $display("FAIL");
      $finish;
    end else if (rst_n) begin
      if (out_valid && out_ready)
        check_word(out_data);
      if (cfg_we)
        shadow_withdraw = cfg_wdata;
      if (in_valid && in_ready) begin
        n = predict_line_words(in_data);
        // swap the computed answer for the typed-in one
        if (row_pinned) begin
          repeat (n) void'(pending_words.pop_back());
          pending_words.push_back(row_word);
        end
      end
    end
  end

  // Result side: draw a wait per word, or hold off for a long stretch when
  // asked, so the block fills up and drops in_ready.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = rx_steady ? 0 : $urandom_range(0, 9);
      if (jam_cycles > 0) begin
        gap        = jam_cycles;
        jam_cycles = 0;
      end
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid && jam_cycles == 0);
    end
  end

  // Offer one word after a drawn gap and hold it until it is accepted.
  // Valid stays up across back-to-back words.
  task automatic send_item(logic rt, logic [7:0] b, logic pinned, lerb_out_t word);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data    = '{req_type: rt, rx_byte: b};
    row_pinned = pinned;
    row_word   = word;
    in_valid   = 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(REQ_BYTE, b, 1'b0, '0);
  endtask

  task automatic send_poll();
    send_item(REQ_POLL, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // Drop valid and drain: every expected word back, then a few more cycles
  // for a byte that may still be in flight.
  task automatic wait_idle();
    @(negedge clk);
    in_valid   = 1'b0;
    row_pinned = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_withdraw(logic [7:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    settings_seen++;
  endtask

  // A byte that is appended as a plain character under the current setting.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_CR || c == CH_LF || c == CH_BS || c == shadow_withdraw);
    return c;
  endfunction

  // Mostly edited lines with random content, each polled and most of them
  // closed first; the rest is raw noise.
  task automatic run_traffic(int n_items);
    int stop_at;
    int len;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) < 7) begin
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 12);
        for (int i = 0; i < len; i++) begin
          send_byte(plain_char());
          if ($urandom_range(0, 7) == 0) send_byte(CH_BS);
          if ($urandom_range(0, 19) == 0) send_poll();
        end
        case ($urandom_range(0, 4))
          0: send_byte(CH_CR);
          1: send_byte(CH_LF);
          2: send_byte(shadow_withdraw);
          3: send_byte(CH_CR);
          default: ;   // leave the line open
        endcase
        send_poll();
        if ($urandom_range(0, 2) == 0) send_poll();
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end
  endtask

  initial begin
    logic [7:0] settings [NUM_SETTINGS];
    stim_row_t  row;
    settings = '{WITHDRAW_RESET, 8'h00, 8'hFF, CH_CR, CH_BS, CH_LF,
                 8'($urandom_range(0, 255))};
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 8'h00;
    in_valid        = 1'b0;
    in_data         = '0;
    row_pinned      = 1'b0;
    row_word        = '0;
    shadow_fill     = 0;
    shadow_ready    = 1'b0;
    shadow_changed  = 1'b0;
    shadow_withdraw = WITHDRAW_RESET;
    cycle_count     = 0;
    mismatches      = 0;
    items_sent      = 0;
    words_checked   = 0;
    polls_seen      = 0;
    lines_completed = 0;
    bytes_dropped   = 0;
    settings_seen   = 0;
    tx_steady       = 1'b0;
    rx_steady       = 1'b0;
    jam_cycles      = 0;
    foreach (shadow_line[i]) shadow_line[i] = 8'h00;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed rows run on the reset value of the withdraw character.
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      row = DIRECTED_ROWS[r];
      send_item(row.req_type, row.rx_byte, row.pinned, row.word);
    end

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      write_withdraw(settings[s]);
      tx_steady = (s % 3 == 1);
      rx_steady = (s % 3 == 2);
      if (s == 0) begin
        // Stall the result side for a long stretch while a poll streams a
        // full line; keep offering words so the input backs up. The line
        // overflows, so the last few chars are dropped.
        tx_steady  = 1'b1;
        repeat (3) send_poll();
        jam_cycles = JAM_CYCLES;
        repeat (LINE_DEPTH + 2) send_byte(plain_char());
        send_byte(CH_CR);
        send_poll();
        repeat (3) send_byte(plain_char());
        send_poll();
        tx_steady = 1'b0;
      end
      run_traffic(PHASE_ITEMS);
    end

    wait_idle();
    repeat (LINE_DEPTH + 8) @(posedge clk);

    $display("sent %0d words (%0d polls) under %0d withdraw settings, checked %0d results",
             items_sent, polls_seen, settings_seen, words_checked);
    $display("%0d lines completed, %0d chars dropped on a full line, %0d mismatches",
             lines_completed, bytes_dropped, mismatches);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/lerb_pkg.sv
sv/lerb_ctrl.sv
sv/lerb_dp.sv
sv/line_edit_receive_buffer.sv
tb/tb.sv
